// ===== rtl/rmg_pkg.sv =====
// ----------------------------------------------------------------------------
// rmg_pkg
// Shared types, register codes and the control store of the revolution mesh
// generator.
// ----------------------------------------------------------------------------
package rmg_pkg;

    localparam int IDX_W   = 10;
    localparam int COORD_W = 16;
    localparam int STEP_W  = 4;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [STEP_W-1:0]         step_t;

    typedef enum logic [2:0] {
        CFG_SIDE_COUNT = 3'd0,
        CFG_COS_STEP   = 3'd1,
        CFG_SIN_STEP   = 3'd2,
        CFG_TOP_CAP    = 3'd3,
        CFG_BOTTOM_CAP = 3'd4
    } cfg_index_t;

    localparam logic [3:0] SIDE_RESET = 4'd12;
    localparam coord_t     COS_RESET  = 16'sd14189;
    localparam coord_t     SIN_RESET  = 16'sd8192;
    localparam logic [3:0] SIDE_MIN   = 4'd3;

    typedef struct packed {
        coord_t prof_x;
        coord_t prof_y;
        coord_t prof_z;
        logic   final_point;
    } prof_beat_t;

    typedef struct packed {
        logic   item_kind;
        coord_t vert_x;
        coord_t vert_y;
        coord_t vert_z;
        idx_t   vertex_number;
        idx_t   corner_a;
        idx_t   corner_b;
        idx_t   corner_c;
        logic   run_end;
    } mesh_beat_t;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_RING_V,
        EM_RING_T1,
        EM_RING_T2,
        EM_BOT_V,
        EM_BOT_T,
        EM_TOP_V,
        EM_TOP_T
    } emit_t;

    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_MULX,
        ROT_MULZ,
        ROT_UPD
    } rot_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } cnt_op_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NOKEEP,
        JC_NOTRI,
        JC_NOBOT,
        JC_NOTOP,
        JC_MORE
    } jcond_t;

    typedef enum logic [2:0] {
        ES_NONE,
        ES_RING_V,
        ES_RING_T,
        ES_BOT,
        ES_TOP
    } end_sel_t;

    typedef struct packed {
        emit_t    emit;
        rot_op_t  rot;
        cnt_op_t  cnt;
        jcond_t   jc;
        end_sel_t es;
        step_t    target;
    } ucw_t;

    localparam step_t S_IDLE   = 4'd0;
    localparam step_t S_KEEP   = 4'd1;
    localparam step_t S_RVTX   = 4'd2;
    localparam step_t S_RMULZ  = 4'd3;
    localparam step_t S_RUPD   = 4'd4;
    localparam step_t S_TCHK   = 4'd5;
    localparam step_t S_TRI1   = 4'd6;
    localparam step_t S_TRI2   = 4'd7;
    localparam step_t S_BCHK   = 4'd8;
    localparam step_t S_BVTX   = 4'd9;
    localparam step_t S_BTRI   = 4'd10;
    localparam step_t S_TOPCHK = 4'd11;
    localparam step_t S_TVTX   = 4'd12;
    localparam step_t S_TTRI   = 4'd13;
    localparam step_t S_DONE   = 4'd14;

    function automatic ucw_t ucode(input step_t s);
        ucw_t w;
        w.emit   = EM_NONE;
        w.rot    = ROT_NONE;
        w.cnt    = CNT_HOLD;
        w.jc     = JC_NEVER;
        w.es     = ES_NONE;
        w.target = S_IDLE;
        case (s)
            S_IDLE:   ;
            S_KEEP:   begin w.cnt = CNT_CLR; w.jc = JC_NOKEEP; w.target = S_BCHK; end
            S_RVTX:   begin w.emit = EM_RING_V; w.rot = ROT_MULX; w.es = ES_RING_V; end
            S_RMULZ:  w.rot = ROT_MULZ;
            S_RUPD:
            begin
                w.rot = ROT_UPD; w.cnt = CNT_INC; w.jc = JC_MORE; w.target = S_RVTX;
            end
            S_TCHK:   begin w.cnt = CNT_CLR; w.jc = JC_NOTRI; w.target = S_BCHK; end
            S_TRI1:   w.emit = EM_RING_T1;
            S_TRI2:
            begin
                w.emit = EM_RING_T2; w.es = ES_RING_T; w.cnt = CNT_INC;
                w.jc = JC_MORE; w.target = S_TRI1;
            end
            S_BCHK:   begin w.cnt = CNT_CLR; w.jc = JC_NOBOT; w.target = S_TOPCHK; end
            S_BVTX:   w.emit = EM_BOT_V;
            S_BTRI:
            begin
                w.emit = EM_BOT_T; w.es = ES_BOT; w.cnt = CNT_INC;
                w.jc = JC_MORE; w.target = S_BTRI;
            end
            S_TOPCHK: begin w.cnt = CNT_CLR; w.jc = JC_NOTOP; w.target = S_DONE; end
            S_TVTX:   w.emit = EM_TOP_V;
            S_TTRI:
            begin
                w.emit = EM_TOP_T; w.es = ES_TOP; w.cnt = CNT_INC;
                w.jc = JC_MORE; w.target = S_TTRI;
            end
            S_DONE:   begin w.jc = JC_ALWAYS; w.target = S_IDLE; end
            default:  begin w.jc = JC_ALWAYS; w.target = S_IDLE; end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/rmg_rotator.sv =====
// ----------------------------------------------------------------------------
// rmg_rotator
// Y-axis rotation of one vertex by the Q2.14 step, two multipliers over two
// steps, round half up and saturate.
// ----------------------------------------------------------------------------
module rmg_rotator (
    input  logic             clk,
    input  rmg_pkg::rot_op_t op,
    input  rmg_pkg::coord_t  cos_c,
    input  rmg_pkg::coord_t  sin_s,
    input  rmg_pkg::coord_t  vx,
    input  rmg_pkg::coord_t  vz,
    output rmg_pkg::coord_t  nx,
    output rmg_pkg::coord_t  nz
);

    logic signed [31:0] pa_reg;
    logic signed [31:0] pb_reg;
    rmg_pkg::coord_t    nx_reg;

    function automatic rmg_pkg::coord_t rnd_sat(input logic signed [32:0] acc);
        logic signed [33:0] r;
        logic signed [19:0] q;
        rmg_pkg::coord_t    res;
        r = 34'(acc) + 34'sd8192;
        q = 20'(r >>> 14);
        if (q > 20'sd32767)
            res = 16'sh7FFF;
        else if (q < -20'sd32768)
            res = 16'sh8000;
        else
            res = 16'(q);
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        case (op)
            rmg_pkg::ROT_MULX:
            begin
                pa_reg <= cos_c * vx;
                pb_reg <= sin_s * vz;
            end
            rmg_pkg::ROT_MULZ:
            begin
                pa_reg <= cos_c * vz;
                pb_reg <= sin_s * vx;
                nx_reg <= rnd_sat(33'(pa_reg) + 33'(pb_reg));
            end
            default: ;
        endcase
    end

    assign nx = nx_reg;
    assign nz = rnd_sat(33'(pa_reg) - 33'(pb_reg));

endmodule

// ===== rtl/revolution_mesh_generator_unit.sv =====
// ----------------------------------------------------------------------------
// revolution_mesh_generator_unit
// Surface-of-revolution tessellator: rings of rotated vertices, joining
// triangles and cap fans, run by a microcoded step sequencer.
// ----------------------------------------------------------------------------
// Throughput: one point at a time; the keep step follows each accepted beat,
// then its ring takes three steps per vertex in the shared rotator, joining
// triangles two steps per side, and each cap on the final point a vertex
// step and one step per side, besides check and done steps. Results leave
// through one output register, one beat a cycle while mesh_ready allows.
// Reset: control registers take set values at once, no clearing pass; data ones do not.
// ----------------------------------------------------------------------------
module revolution_mesh_generator_unit #(
    parameter int MAX_SIDES = 12,
    parameter int MAX_RINGS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                prof_valid,
    output logic                prof_ready,
    input  rmg_pkg::prof_beat_t prof,
    output logic                mesh_valid,
    input  logic                mesh_ready,
    output rmg_pkg::mesh_beat_t mesh
);

    localparam int SW = $clog2(MAX_SIDES + 1);
    localparam int RW = $clog2(MAX_RINGS + 1);
    localparam int IW = rmg_pkg::IDX_W;

    // configuration
    logic [3:0]      side_count_reg;
    rmg_pkg::coord_t cos_step_reg;
    rmg_pkg::coord_t sin_step_reg;
    logic            top_cap_reg;
    logic            bottom_cap_reg;

    // profile state
    logic [RW-1:0]   ring_total_reg;
    logic            seen_first_reg;
    rmg_pkg::coord_t top_height_reg;
    rmg_pkg::coord_t first_height_reg;
    logic            reversed_reg;

    // current point
    rmg_pkg::coord_t vx_reg;
    rmg_pkg::coord_t vz_reg;
    rmg_pkg::coord_t y_reg;
    logic [IW-1:0]   base_reg;
    logic [SW-1:0]   side_reg;
    logic            fin_reg;
    logic            keep_reg;
    logic            tris_reg;
    logic            bot_en_reg;
    logic            top_en_reg;
    logic            caps_any_reg;

    // sequencer
    rmg_pkg::step_t  pc_reg;
    rmg_pkg::step_t  pc_next;
    logic [SW-1:0]   p_reg;
    logic [SW-1:0]   p_next;
    rmg_pkg::ucw_t   cw;
    logic            adv;
    logic            taken;
    logic            slot_free;
    logic            load;
    logic            prof_fire;

    logic                mesh_valid_reg;
    logic                mesh_valid_next;
    rmg_pkg::mesh_beat_t mesh_reg;
    rmg_pkg::mesh_beat_t beat;

    rmg_pkg::rot_op_t rot_op;
    rmg_pkg::coord_t  nx;
    rmg_pkg::coord_t  nz;

    // accept-time values
    logic [3:0]         side_clamp;
    logic [SW-1:0]      side_acc;
    logic               is_first;
    logic               keep_acc;
    logic               rings_after;
    logic [RW+SW-1:0]   base_prod;

    // index arithmetic
    logic [IW-1:0] sd;
    logic [IW-1:0] pi;
    logic [IW-1:0] ii;
    logic [IW-1:0] cb;
    logic [IW-1:0] st;
    logic [IW-1:0] tc;
    logic [IW-1:0] p1;
    logic [IW-1:0] pm;
    logic [IW-1:0] swap_t;
    logic          p_last;
    logic          p_zero;

    assign prof_ready = (pc_reg == rmg_pkg::S_IDLE);
    assign prof_fire  = prof_valid && prof_ready;
    assign mesh_valid = mesh_valid_reg;
    assign mesh       = mesh_reg;

    always_comb
    begin
        side_clamp = side_count_reg;
        if (side_count_reg < rmg_pkg::SIDE_MIN)
            side_clamp = rmg_pkg::SIDE_MIN;
        else if (side_count_reg > 4'(MAX_SIDES))
            side_clamp = 4'(MAX_SIDES);
        side_acc    = SW'(side_clamp);
        is_first    = !seen_first_reg;
        keep_acc    = !((prof.prof_x == 16'sd0) && (is_first || prof.final_point))
                      && (ring_total_reg < RW'(MAX_RINGS));
        rings_after = (ring_total_reg != '0) || keep_acc;
        base_prod   = ring_total_reg * side_acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg <= rmg_pkg::SIDE_RESET;
            cos_step_reg   <= rmg_pkg::COS_RESET;
            sin_step_reg   <= rmg_pkg::SIN_RESET;
            top_cap_reg    <= 1'b1;
            bottom_cap_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rmg_pkg::CFG_SIDE_COUNT: side_count_reg <= cfg_data[3:0];
                rmg_pkg::CFG_COS_STEP:   cos_step_reg   <= cfg_data;
                rmg_pkg::CFG_SIN_STEP:   sin_step_reg   <= cfg_data;
                rmg_pkg::CFG_TOP_CAP:    top_cap_reg    <= cfg_data[0];
                rmg_pkg::CFG_BOTTOM_CAP: bottom_cap_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_total_reg   <= '0;
            seen_first_reg   <= 1'b0;
            top_height_reg   <= '0;
            first_height_reg <= '0;
            reversed_reg     <= 1'b0;
            side_reg         <= SW'(rmg_pkg::SIDE_MIN);
            fin_reg          <= 1'b0;
            keep_reg         <= 1'b0;
            tris_reg         <= 1'b0;
            bot_en_reg       <= 1'b0;
            top_en_reg       <= 1'b0;
            caps_any_reg     <= 1'b0;
        end
        else if (prof_fire)
        begin
            if (is_first)
            begin
                top_height_reg <= prof.prof_y;
                seen_first_reg <= 1'b1;
            end
            if (keep_acc)
            begin
                ring_total_reg <= ring_total_reg + RW'(1);
                if (ring_total_reg == RW'(0))
                    first_height_reg <= prof.prof_y;
                if (ring_total_reg == RW'(1))
                    reversed_reg <= !(first_height_reg > prof.prof_y);
            end
            side_reg     <= side_acc;
            fin_reg      <= prof.final_point;
            keep_reg     <= keep_acc;
            tris_reg     <= keep_acc && (ring_total_reg != '0);
            bot_en_reg   <= prof.final_point && rings_after && bottom_cap_reg;
            top_en_reg   <= prof.final_point && rings_after && top_cap_reg;
            caps_any_reg <= prof.final_point && rings_after
                            && (bottom_cap_reg || top_cap_reg);
        end
        else if ((pc_reg == rmg_pkg::S_DONE) && fin_reg)
        begin
            ring_total_reg   <= '0;
            seen_first_reg   <= 1'b0;
            top_height_reg   <= '0;
            first_height_reg <= '0;
            reversed_reg     <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prof_fire)
        begin
            vx_reg   <= prof.prof_x;
            vz_reg   <= prof.prof_z;
            y_reg    <= prof.prof_y;
            base_reg <= IW'(base_prod);
        end
        else if (adv && (cw.rot == rmg_pkg::ROT_UPD))
        begin
            vx_reg <= nx;
            vz_reg <= nz;
        end
    end

    // sequencer
    assign cw        = rmg_pkg::ucode(pc_reg);
    assign slot_free = !mesh_valid_reg || mesh_ready;
    assign p_last    = (p_reg == side_reg - SW'(1));
    assign p_zero    = (p_reg == '0);

    always_comb
    begin
        if (pc_reg == rmg_pkg::S_IDLE)
            adv = prof_fire;
        else
            adv = (cw.emit == rmg_pkg::EM_NONE) || slot_free;
        load = adv && (cw.emit != rmg_pkg::EM_NONE);
        case (cw.jc)
            rmg_pkg::JC_ALWAYS: taken = 1'b1;
            rmg_pkg::JC_NOKEEP: taken = !keep_reg;
            rmg_pkg::JC_NOTRI:  taken = !tris_reg;
            rmg_pkg::JC_NOBOT:  taken = !bot_en_reg;
            rmg_pkg::JC_NOTOP:  taken = !top_en_reg;
            rmg_pkg::JC_MORE:   taken = !p_last;
            default:            taken = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        p_next  = p_reg;
        if (adv)
        begin
            pc_next = taken ? cw.target : pc_reg + rmg_pkg::step_t'(1);
            case (cw.cnt)
                rmg_pkg::CNT_CLR: p_next = '0;
                rmg_pkg::CNT_INC: p_next = p_reg + SW'(1);
                default:          p_next = p_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rmg_pkg::S_IDLE;
            p_reg  <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            p_reg  <= p_next;
        end
    end

    assign rot_op = adv ? cw.rot : rmg_pkg::ROT_NONE;

    rmg_rotator u_rot (
        .clk   (clk),
        .op    (rot_op),
        .cos_c (cos_step_reg),
        .sin_s (sin_step_reg),
        .vx    (vx_reg),
        .vz    (vz_reg),
        .nx    (nx),
        .nz    (nz)
    );

    // result assembly
    always_comb
    begin
        sd = IW'(side_reg);
        pi = IW'(p_reg);
        ii = base_reg + pi;
        cb = keep_reg ? base_reg + sd : base_reg;
        st = cb - sd;
        tc = cb + IW'(bot_en_reg);
        p1 = p_last ? '0 : pi + IW'(1);
        pm = p_zero ? sd - IW'(1) : pi - IW'(1);

        beat = '0;
        case (cw.emit)
            rmg_pkg::EM_RING_V:
            begin
                beat.vert_x        = vx_reg;
                beat.vert_y        = y_reg;
                beat.vert_z        = vz_reg;
                beat.vertex_number = ii;
            end
            rmg_pkg::EM_RING_T1:
            begin
                beat.item_kind = rmg_pkg::KIND_TRIANGLE;
                beat.corner_a  = ii - sd;
                beat.corner_b  = p_zero ? ii - IW'(1) : ii - sd - IW'(1);
                beat.corner_c  = ii;
            end
            rmg_pkg::EM_RING_T2:
            begin
                beat.item_kind = rmg_pkg::KIND_TRIANGLE;
                beat.corner_a  = p_zero ? ii - IW'(1) : ii - sd - IW'(1);
                beat.corner_b  = p_zero ? ii + sd - IW'(1) : ii - IW'(1);
                beat.corner_c  = ii;
            end
            rmg_pkg::EM_BOT_V:
            begin
                beat.vert_y        = y_reg;
                beat.vertex_number = cb;
            end
            rmg_pkg::EM_BOT_T:
            begin
                beat.item_kind = rmg_pkg::KIND_TRIANGLE;
                beat.corner_a  = cb;
                beat.corner_b  = st + p1;
                beat.corner_c  = st + pi;
            end
            rmg_pkg::EM_TOP_V:
            begin
                beat.vert_y        = top_height_reg;
                beat.vertex_number = tc;
            end
            rmg_pkg::EM_TOP_T:
            begin
                beat.item_kind = rmg_pkg::KIND_TRIANGLE;
                beat.corner_a  = pi;
                beat.corner_b  = tc;
                beat.corner_c  = pm;
            end
            default: ;
        endcase

        swap_t = beat.corner_b;
        if ((beat.item_kind == rmg_pkg::KIND_TRIANGLE) && reversed_reg)
        begin
            beat.corner_b = beat.corner_c;
            beat.corner_c = swap_t;
        end

        case (cw.es)
            rmg_pkg::ES_RING_V: beat.run_end = p_last && !tris_reg && !caps_any_reg;
            rmg_pkg::ES_RING_T: beat.run_end = p_last && !caps_any_reg;
            rmg_pkg::ES_BOT:    beat.run_end = p_last && !top_en_reg;
            rmg_pkg::ES_TOP:    beat.run_end = p_last;
            default:            beat.run_end = 1'b0;
        endcase
    end

    always_comb
    begin
        if (load)
            mesh_valid_next = 1'b1;
        else if (mesh_ready)
            mesh_valid_next = 1'b0;
        else
            mesh_valid_next = mesh_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mesh_valid_reg <= 1'b0;
        else
            mesh_valid_reg <= mesh_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            mesh_reg <= beat;
    end

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        prof_fire |=> !prof_ready)
        else $error("input taken while a point is in progress");

    // the counter still holds the last point's value until the keep step clears it
    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg != rmg_pkg::S_IDLE) && (pc_reg != rmg_pkg::S_KEEP)) |->
        (p_reg <= side_reg))
        else $error("step counter beyond side count");

    a_ring_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ring_total_reg <= RW'(MAX_RINGS))
        else $error("ring count beyond limit");

    a_tri_corners: assert property (@(posedge clk) disable iff (!rst_n)
        (mesh_valid_reg && (mesh_reg.item_kind == rmg_pkg::KIND_TRIANGLE)) |->
        ((mesh_reg.corner_a != mesh_reg.corner_b) && (mesh_reg.corner_a != mesh_reg.corner_c)
         && (mesh_reg.corner_b != mesh_reg.corner_c)))
        else $error("degenerate triangle beat");

endmodule
